FILE: sv/tkdst_pkg.sv
`timescale 1ns / 1ps
package tkdst_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned RankW = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic ins;   // insert the request value into the table
    logic load;  // load the output register from the current rank
    logic last;  // current rank is the final held entry
  } tkdst_cmd_t;

endpackage

FILE: sv/tkdst_dp.sv
`timescale 1ns / 1ps
module tkdst_dp import tkdst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 5,
  parameter int unsigned CntW        = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tkdst_cmd_t             cmd_i,
  input  logic [IdxW-1:0]        idx_i,
  input  logic signed [ValW-1:0] new_value_i,
  output logic [CntW-1:0]        cnt_o,
  output logic [RankW-1:0]       rank_o,
  output logic signed [ValW-1:0] entry_value_o,
  output logic                   accepted_o,
  output logic                   last_entry_o
);

  logic signed [ValW-1:0] entry_q [TABLE_DEPTH];
  logic signed [ValW-1:0] entry_d [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge;
  logic [TABLE_DEPTH-1:0] eq;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   acc_q, acc_d;
  logic                   take;
  logic [RankW-1:0]       rank_nxt;

  logic [RankW-1:0]       rank_q;
  logic signed [ValW-1:0] val_q;
  logic                   oacc_q;
  logic                   last_q;

  // Per-slot compare against the offered value; only held slots count
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge[i] = (CntW'(i) < cnt_q) && (entry_q[i] >= new_value_i);
      eq[i] = (CntW'(i) < cnt_q) && (entry_q[i] == new_value_i);
    end
  end

  // Drop duplicates and values not above the smallest entry of a full table
  assign take = !(|eq) && !ge[TABLE_DEPTH-1];

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      entry_d[i] = entry_q[i];
      if (cmd_i.ins && take && !ge[i]) begin
        if (i == 0) begin
          entry_d[i] = new_value_i;
        end else if (ge[i-1]) begin
          entry_d[i] = new_value_i;
        end else begin
          entry_d[i] = entry_q[i-1];
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    if (cmd_i.ins) begin
      acc_d = take;
      if (take && (cnt_q != CntW'(TABLE_DEPTH))) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      acc_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      entry_q[i] <= entry_d[i];
    end
  end

  assign rank_nxt = RankW'(idx_i) + RankW'(1);

  // Output register; the table may be updated while it holds a result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_q <= rank_nxt;
      val_q  <= entry_q[idx_i];
      oacc_q <= acc_q;
      last_q <= cmd_i.last;
    end
  end

  assign cnt_o         = cnt_q;
  assign rank_o        = rank_q;
  assign entry_value_o = val_q;
  assign accepted_o    = oacc_q;
  assign last_entry_o  = last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins && take && (cnt_q != CntW'(TABLE_DEPTH)) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("taken value did not grow the table");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ins |=> $stable(cnt_q))
    else $error("entry count changed without an insert");

endmodule

FILE: sv/tkdst_ctrl.sv
`timescale 1ns / 1ps
module tkdst_ctrl import tkdst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 5,
  parameter int unsigned CntW        = $clog2(TABLE_DEPTH + 1),
  parameter int unsigned IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  logic [CntW-1:0] cnt_i,
  output tkdst_cmd_t      cmd_o,
  output logic [IdxW-1:0] idx_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic            state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            ovld_q, ovld_d;
  logic            load;
  logic            last;
  logic            in_rdy;

  assign last   = ((CntW + 1)'(idx_q) + (CntW + 1)'(1)) == (CntW + 1)'(cnt_i);
  assign load   = (state_q == ST_EMIT) && (!ovld_q || !out_stall_i);
  // Take a request while idle, or in the cycle the final rank moves to the output
  assign in_rdy = (state_q == ST_IDLE) || (load && last);

  assign cmd_o.ins  = in_valid_i && in_rdy;
  assign cmd_o.load = load;
  assign cmd_o.last = last;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.ins) begin
          state_d = ST_EMIT;
          idx_d   = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (last) begin
            state_d = cmd_o.ins ? ST_EMIT : ST_IDLE;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      ovld_d = 1'b1;
    end else if (out_stall_i) begin
      ovld_d = ovld_q;
    end else begin
      ovld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ovld_q  <= ovld_d;
    end
  end

  assign in_stall_o  = !in_rdy;
  assign out_valid_o = ovld_q;
  assign idx_o       = idx_q;

  a_idx_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (CntW + 1)'(idx_q) < (CntW + 1)'(cnt_i))
    else $error("emit index beyond held entries");

  a_ins_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |-> (state_q == ST_IDLE) || (load && last))
    else $error("insert while the list is still being sent");

  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ins |=> (state_q == ST_EMIT) && (idx_q == '0))
    else $error("insert not followed by list from rank one");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !load)
    else $error("output load while idle");

endmodule

FILE: sv/top_k_distinct_sorted_table_unit.sv
`timescale 1ns / 1ps
// A request is inserted at its accept edge; rank 1 is then loaded into the output register.
// Each request's list holds the entries held after the insert (1 to TABLE_DEPTH); the output
//   register sends one ranked entry per cycle while out_stall_i does not hold it.
// A new request is taken in the same cycle the final entry moves to the output register.
// Reset (rst_ni, asynchronous, active low) empties the table and drops any list in flight.
module top_k_distinct_sorted_table_unit import tkdst_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [ValW-1:0] new_value_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [RankW-1:0]       rank_o,
  output logic signed [ValW-1:0] entry_value_o,
  output logic                   accepted_o,
  output logic                   last_entry_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  tkdst_cmd_t      cmd;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] cnt;

  tkdst_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CntW        (CntW),
    .IdxW        (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cnt_i       (cnt),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  tkdst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CntW        (CntW),
    .IdxW        (IdxW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .idx_i         (idx),
    .new_value_i   (new_value_i),
    .cnt_o         (cnt),
    .rank_o        (rank_o),
    .entry_value_o (entry_value_o),
    .accepted_o    (accepted_o),
    .last_entry_o  (last_entry_o)
  );

endmodule
